/* src/aeit_pkg.sv */
package aeit_pkg;

    // operand widths
    localparam int unsigned RATE_W  = 8;
    localparam int unsigned GRAN_W  = 10;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned CNT_W   = 5;

    // timeout scale in ms per unit of base rate
    localparam logic [8:0] TIMEOUT_FACTOR = 9'd400;

    // one quotient bit per divider step
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd16;

    // register map, indexed by word address
    localparam logic REG_BASE_RATE   = 1'b0;
    localparam logic REG_GRANULARITY = 1'b1;

    localparam logic [RATE_W-1:0] BASE_RATE_RST   = 8'd60;
    localparam logic [GRAN_W-1:0] GRANULARITY_RST = 10'd1;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // ending modes
    localparam logic MODE_PVARP = 1'b0;
    localparam logic MODE_BP    = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic div_start;
        logic div_step;
        logic div_finish;
        logic step_eval;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic active;
    } t_stat;

endpackage

/* src/aeit_ctrl.sv */
module aeit_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  aeit_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output aeit_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [aeit_pkg::CNT_W-1:0]  r_cnt;
    logic [aeit_pkg::CNT_W-1:0]  n_cnt;
    logic                        w_accept;
    logic                        w_start;

    // a word is taken only when idle and the result register can take its answer
    assign o_in_stall = !((r_state == S_IDLE) && i_stat.out_free);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_start    = (i_req_type == aeit_pkg::REQ_START) && !i_stat.active;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_start) begin
                        o_cmd.div_start = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_DIV;
                    end else begin
                        o_cmd.step_eval = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == aeit_pkg::DIV_LAST) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (i_stat.out_free) begin
                    o_cmd.div_finish = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* src/aeit_dpath.sv */
module aeit_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  aeit_pkg::t_cmd               i_cmd,
    output aeit_pkg::t_stat              o_stat,
    input  logic [aeit_pkg::RATE_W-1:0]  i_base_rate,
    input  logic [aeit_pkg::GRAN_W-1:0]  i_granularity_ms,
    input  logic                         i_req_type,
    input  logic [aeit_pkg::RATE_W-1:0]  i_rate_ppm,
    input  logic                         i_ventricular_sense,
    input  logic                         i_atrial_sense,
    input  logic                         i_tick,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_interval_done,
    output logic                         o_next_mode,
    output logic                         o_atrial_pace,
    output logic                         o_running
);

    localparam int unsigned RW = aeit_pkg::RATE_W;
    localparam int unsigned CW = aeit_pkg::COUNT_W;

    logic          r_active;
    logic [CW-1:0] r_remaining;
    logic [RW-1:0] r_div;
    logic [RW-1:0] r_rem;
    logic [CW-1:0] r_quo;
    logic          r_out_valid;
    logic          r_done;
    logic          r_mode;
    logic          r_pace;
    logic          r_running;

    logic [CW-1:0] w_dividend;
    logic [RW-1:0] w_rate_clamp;
    logic [RW:0]   w_partial;
    logic [RW+1:0] w_trial;
    logic          w_qbit;
    logic          w_expire;

    logic          n_active;
    logic [CW-1:0] n_remaining;
    logic          n_done;
    logic          n_mode;
    logic          n_pace;
    logic          n_running;
    logic          w_load;

    // timeout dividend, fits 17 bits for any 8-bit base rate
    assign w_dividend   = CW'(i_base_rate * aeit_pkg::TIMEOUT_FACTOR);
    assign w_rate_clamp = (i_rate_ppm == '0) ? RW'(1) : i_rate_ppm;

    // restoring divide: one quotient bit per step
    assign w_partial = {r_rem, r_quo[CW-1]};
    assign w_trial   = {1'b0, w_partial} - {2'b00, r_div};
    assign w_qbit    = !w_trial[RW+1];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div <= w_rate_clamp;
            r_rem <= '0;
            r_quo <= w_dividend;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_trial[RW-1:0] : w_partial[RW-1:0];
            r_quo <= {r_quo[CW-2:0], w_qbit};
        end
    end

    // tick expiry compare
    assign w_expire = {{(CW-aeit_pkg::GRAN_W){1'b0}}, i_granularity_ms} >= r_remaining;

    // result of a step word or of a finished start
    always_comb begin
        n_active    = r_active;
        n_remaining = r_remaining;
        n_done      = 1'b0;
        n_mode      = aeit_pkg::MODE_PVARP;
        n_pace      = 1'b0;
        if (i_cmd.div_finish) begin
            n_remaining = r_quo;
            if (r_quo == '0) begin
                n_active = 1'b0;
                n_done   = 1'b1;
                n_mode   = aeit_pkg::MODE_BP;
                n_pace   = 1'b1;
            end else begin
                n_active = 1'b1;
            end
        end else if (i_req_type == aeit_pkg::REQ_STEP && r_active) begin
            if (i_ventricular_sense) begin
                n_active = 1'b0;
                n_done   = 1'b1;
                n_mode   = aeit_pkg::MODE_PVARP;
            end else if (i_atrial_sense) begin
                n_active = 1'b0;
                n_done   = 1'b1;
                n_mode   = aeit_pkg::MODE_BP;
            end else if (i_tick) begin
                if (w_expire) begin
                    n_remaining = '0;
                    n_active    = 1'b0;
                    n_done      = 1'b1;
                    n_mode      = aeit_pkg::MODE_BP;
                    n_pace      = 1'b1;
                end else begin
                    n_remaining = r_remaining - CW'(i_granularity_ms);
                end
            end
        end
        n_running = n_active;
    end

    assign w_load = i_cmd.div_finish || i_cmd.step_eval;

    // interval state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_remaining <= '0;
        end else if (w_load) begin
            r_active    <= n_active;
            r_remaining <= n_remaining;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_done    <= n_done;
            r_mode    <= n_mode;
            r_pace    <= n_pace;
            r_running <= n_running;
        end
    end

    assign o_stat = '{out_free: (!r_out_valid || !i_out_stall), active: r_active};

    assign o_out_valid     = r_out_valid;
    assign o_interval_done = r_done;
    assign o_next_mode     = r_mode;
    assign o_atrial_pace   = r_pace;
    assign o_running       = r_running;

    // an ended interval never reports itself still running
    a_done_not_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_done && r_running))
        else $error("interval ended but still running");

    // a pace always ends the interval toward BP
    a_pace_ends_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pace) |-> (r_done && r_mode == aeit_pkg::MODE_BP))
        else $error("pace without BP ending");

    // next mode is only set on an ending word
    a_mode_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_mode) |-> r_done)
        else $error("next mode set without interval end");

    // interval state moves only on a result load
    a_active_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_active)) |-> $past(w_load))
        else $error("active changed without result load");

endmodule

/* src/atrial_escape_interval_timer_core.sv */
// atrial escape interval timer core
// step word: result registered in the cycle after accept, one word per cycle while output drains
// start word (idle interval): restoring divide of 17 quotient bits, result registered once the output is free
// the divider holds off the input channel until the start result is registered
// reset (synchronous, active low): interval idle, count 0, base_rate 60, granularity_ms 1
module atrial_escape_interval_timer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [aeit_pkg::RATE_W-1:0]  i_rate_ppm,
    input  logic                         i_ventricular_sense,
    input  logic                         i_atrial_sense,
    input  logic                         i_tick,
    // output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_interval_done,
    output logic                         o_next_mode,
    output logic                         o_atrial_pace,
    output logic                         o_running
);

    logic [aeit_pkg::RATE_W-1:0] r_base_rate;
    logic [aeit_pkg::GRAN_W-1:0] r_granularity;
    logic                        w_cfg_wr;
    aeit_pkg::t_cmd              w_cmd;
    aeit_pkg::t_stat             w_stat;

    // config registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_rate   <= aeit_pkg::BASE_RATE_RST;
            r_granularity <= aeit_pkg::GRANULARITY_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                aeit_pkg::REG_BASE_RATE:   r_base_rate   <= pwdata[aeit_pkg::RATE_W-1:0];
                aeit_pkg::REG_GRANULARITY: r_granularity <= pwdata[aeit_pkg::GRAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            aeit_pkg::REG_BASE_RATE:   prdata = {{(32-aeit_pkg::RATE_W){1'b0}}, r_base_rate};
            aeit_pkg::REG_GRANULARITY: prdata = {{(32-aeit_pkg::GRAN_W){1'b0}}, r_granularity};
            default:                   prdata = '0;
        endcase
    end

    aeit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    aeit_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_base_rate         (r_base_rate),
        .i_granularity_ms    (r_granularity),
        .i_req_type          (i_req_type),
        .i_rate_ppm          (i_rate_ppm),
        .i_ventricular_sense (i_ventricular_sense),
        .i_atrial_sense      (i_atrial_sense),
        .i_tick              (i_tick),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_interval_done     (o_interval_done),
        .o_next_mode         (o_next_mode),
        .o_atrial_pace       (o_atrial_pace),
        .o_running           (o_running)
    );

endmodule
